@@ src/adn_pkg.sv @@
`timescale 1ns / 1ps

package adn_pkg;

   localparam int ByteWidth = 8;

   localparam logic [ByteWidth-1:0] AdTypeNameComplete = 8'h09;
   localparam logic [ByteWidth-1:0] AdTypeNameShort    = 8'h08;
   localparam logic [ByteWidth-1:0] MaxNameLenReset    = 8'd31;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_LEN  = 6'b000010,
      PH_TYPE = 6'b000100,
      PH_NAME = 6'b001000,
      PH_SKIP = 6'b010000,
      PH_STOP = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 first_byte;
      logic [ByteWidth-1:0] packet_length;
   } item_type;

   typedef struct packed {
      logic                 name_valid;
      logic [ByteWidth-1:0] name_byte;
      logic                 packet_done;
      logic                 name_found;
      logic                 malformed;
      logic [ByteWidth-1:0] name_length;
   } result_type;

endpackage

@@ src/adn_channels.sv @@
`timescale 1ns / 1ps

interface adn_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic [7:0] packet_length;

   modport source (output valid, output data_byte, output first_byte,
                   output packet_length, input ready);
   modport sink (input valid, input data_byte, input first_byte,
                 input packet_length, output ready);
   modport monitor (input valid, input ready, input data_byte, input first_byte,
                    input packet_length);
endinterface

interface adn_rsp_if;
   logic       valid;
   logic       ready;
   logic       name_valid;
   logic [7:0] name_byte;
   logic       packet_done;
   logic       name_found;
   logic       malformed;
   logic [7:0] name_length;

   modport source (output valid, output name_valid, output name_byte,
                   output packet_done, output name_found, output malformed,
                   output name_length, input ready);
   modport sink (input valid, input name_valid, input name_byte,
                 input packet_done, input name_found, input malformed,
                 input name_length, output ready);
   modport monitor (input valid, input ready, input name_valid, input name_byte,
                    input packet_done, input name_found, input malformed,
                    input name_length);
endinterface

@@ src/adn_in_reg.sv @@
`timescale 1ns / 1ps

module adn_in_reg (
   input  logic              clock,
   input  logic              reset,
   adn_req_if.sink           req_chan,
   input  logic              take,
   output logic              item_valid,
   output adn_pkg::item_type item
);

   logic              valid_ff;
   logic              valid_in;
   adn_pkg::item_type item_ff;
   logic              load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte     <= req_chan.data_byte;
         item_ff.first_byte    <= req_chan.first_byte;
         item_ff.packet_length <= req_chan.packet_length;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ src/adn_parser.sv @@
`timescale 1ns / 1ps

module adn_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                step,
   input  adn_pkg::item_type   item,
   output logic                res_valid,
   output adn_pkg::result_type result
);

   adn_pkg::phase_type phase_ff, phase_in;
   logic [7:0] pkt_left_ff, pkt_left_in;
   logic [7:0] fld_left_ff, fld_left_in;
   logic [7:0] count_ff, count_in;
   logic       found_ff, found_in;
   logic       mal_ff, mal_in;
   logic [7:0] max_len_ff;

   always_comb begin
      logic       emit;
      logic       done;
      logic       active;
      logic [7:0] b;
      logic [7:0] fld_dec;

      b           = item.data_byte;
      emit        = 1'b0;
      done        = 1'b0;
      active      = 1'b1;
      phase_in    = phase_ff;
      pkt_left_in = pkt_left_ff;
      fld_left_in = fld_left_ff;
      count_in    = count_ff;
      found_in    = found_ff;
      mal_in      = mal_ff;

      if (item.first_byte) begin
         found_in    = 1'b0;
         mal_in      = 1'b0;
         count_in    = '0;
         fld_left_in = '0;
         if (item.packet_length == '0) begin
            phase_in    = adn_pkg::PH_IDLE;
            pkt_left_in = '0;
            done        = 1'b1;
            active      = 1'b0;
         end else begin
            pkt_left_in = item.packet_length;
            phase_in    = adn_pkg::PH_LEN;
         end
      end else if (phase_ff == adn_pkg::PH_IDLE || pkt_left_ff == '0) begin
         phase_in = adn_pkg::PH_IDLE;
         active   = 1'b0;
      end

      fld_dec = fld_left_in - 8'd1;

      if (active) begin
         case (phase_in)
            adn_pkg::PH_LEN: begin
               if (b == '0 || ({1'b0, b} + 9'd1) > {1'b0, pkt_left_in}) begin
                  mal_in   = 1'b1;
                  phase_in = adn_pkg::PH_STOP;
               end else begin
                  fld_left_in = b;
                  phase_in    = adn_pkg::PH_TYPE;
               end
            end
            adn_pkg::PH_TYPE: begin
               fld_left_in = fld_dec;
               if (b == adn_pkg::AdTypeNameComplete || b == adn_pkg::AdTypeNameShort) begin
                  found_in = 1'b1;
                  phase_in = (fld_dec == '0) ? adn_pkg::PH_STOP : adn_pkg::PH_NAME;
               end else begin
                  phase_in = (fld_dec == '0) ? adn_pkg::PH_LEN : adn_pkg::PH_SKIP;
               end
            end
            adn_pkg::PH_NAME: begin
               if (count_in < max_len_ff) begin
                  emit     = 1'b1;
                  count_in = count_in + 8'd1;
               end
               fld_left_in = fld_dec;
               if (fld_dec == '0) begin
                  phase_in = adn_pkg::PH_STOP;
               end
            end
            adn_pkg::PH_SKIP: begin
               fld_left_in = fld_dec;
               if (fld_dec == '0) begin
                  phase_in = adn_pkg::PH_LEN;
               end
            end
            default: begin
            end
         endcase

         pkt_left_in = pkt_left_in - 8'd1;
         if (pkt_left_in == '0) begin
            done     = 1'b1;
            phase_in = adn_pkg::PH_IDLE;
         end
      end

      res_valid          = emit || done;
      result.name_valid  = emit;
      result.name_byte   = emit ? b : '0;
      result.packet_done = done;
      result.name_found  = done ? found_in : 1'b0;
      result.malformed   = done ? mal_in : 1'b0;
      result.name_length = done ? count_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= adn_pkg::PH_IDLE;
         pkt_left_ff <= '0;
         fld_left_ff <= '0;
         count_ff    <= '0;
         found_ff    <= 1'b0;
         mal_ff      <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         pkt_left_ff <= pkt_left_in;
         fld_left_ff <= fld_left_in;
         count_ff    <= count_in;
         found_ff    <= found_in;
         mal_ff      <= mal_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= adn_pkg::MaxNameLenReset;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

endmodule

@@ src/adn_out_reg.sv @@
`timescale 1ns / 1ps

module adn_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  adn_pkg::result_type result,
   output logic                free,
   adn_rsp_if.source           rsp_chan
);

   logic                valid_ff;
   logic                valid_in;
   adn_pkg::result_type res_ff;

   assign free     = !valid_ff || rsp_chan.ready;
   assign valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= result;
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.name_valid  = res_ff.name_valid;
   assign rsp_chan.name_byte   = res_ff.name_byte;
   assign rsp_chan.packet_done = res_ff.packet_done;
   assign rsp_chan.name_found  = res_ff.name_found;
   assign rsp_chan.malformed   = res_ff.malformed;
   assign rsp_chan.name_length = res_ff.name_length;

endmodule

@@ src/adv_data_name_extractor.sv @@
`timescale 1ns / 1ps
// Advertising data name extractor.
// req_chan: one advertising byte per beat; first_byte marks a packet start and
//    packet_length is sampled with it. Bytes outside a packet are dropped.
// rsp_chan: one beat per kept name character (name_valid) and one on the
//    packet's last byte (packet_done, with name_found, malformed, name_length).
//    Bytes that produce neither give no beat.
// csr_wr_en/csr_wr_data: max_name_len; the user must write it only while the
//    block is idle, which the block itself does not enforce.
// Throughput: one byte per cycle while rsp_chan is not stalled; the step logic
//    sits between the input register and the result register, and state
//    updates as the byte leaves the input register.
// Reset (synchronous): both registers empty, parser idle, max_name_len 31.
// Receiver stall: the result register holds; the input register takes one more
//    byte if empty, then req_chan.ready drops until the result is taken.
module adv_data_name_extractor (
   input  logic      clock,
   input  logic      reset,
   adn_req_if.sink   req_chan,
   adn_rsp_if.source rsp_chan,
   input  logic      csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic                item_valid;
   adn_pkg::item_type   item;
   logic                out_free;
   logic                take;
   logic                res_valid;
   adn_pkg::result_type result;

   assign take = item_valid && out_free;

   adn_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   adn_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .step        (take),
      .item        (item),
      .res_valid   (res_valid),
      .result      (result)
   );

   adn_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (take && res_valid),
      .result   (result),
      .free     (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ src/adn_checker.sv @@
`timescale 1ns / 1ps

module adn_checker (
   input logic       clock,
   input logic       reset,
   adn_rsp_if.source rsp_mon
);

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_mon.valid && !rsp_mon.ready |=> rsp_mon.valid)
      else $error("result beat dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_mon.valid)
      else $error("result beat present after reset");

   a_beat_meaningful: assert property (@(posedge clock) disable iff (reset)
      rsp_mon.valid |-> (rsp_mon.name_valid || rsp_mon.packet_done))
      else $error("empty result beat");

   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_mon.valid && !rsp_mon.packet_done |->
         (!rsp_mon.name_found && !rsp_mon.malformed && rsp_mon.name_length == 8'd0))
      else $error("status shown before packet end");

   a_byte_zero_unkept: assert property (@(posedge clock) disable iff (reset)
      rsp_mon.valid && !rsp_mon.name_valid |-> rsp_mon.name_byte == 8'd0)
      else $error("name byte set without name_valid");

endmodule

bind adv_data_name_extractor adn_checker u_adn_checker (
   .clock   (clock),
   .reset   (reset),
   .rsp_mon (rsp_chan)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

   localparam int IdlePct     = 33;
   localparam int SettleCycles = 6;
   localparam int HoldCycles   = 300;
   localparam int PhaseBytes   = 225;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_wr_en;
   logic [7:0] csr_wr_data;

   adn_req_if req_chan ();
   adn_rsp_if rsp_chan ();

   adv_data_name_extractor u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   adn_pkg::item_type   pending_bytes[$];
   adn_pkg::result_type name_beats_due[$];
   adn_pkg::item_type   on_wire;
   logic       offering = 1'b0;
   logic       no_idle = 1'b0;
   int         fail_count = 0;
   int         rsp_beats = 0;
   int         hold_left = 0;

   // parser model state
   adn_pkg::phase_type ph;
   logic [7:0] pkt_left;
   logic [7:0] fld_left;
   logic [7:0] nm_cnt;
   logic       fnd;
   logic       mal;
   logic [7:0] max_len_cfg = adn_pkg::MaxNameLenReset;

   task automatic step_parser(input adn_pkg::item_type it);
      adn_pkg::result_type r;
      logic       emit;
      logic       done;
      r    = '0;
      emit = 1'b0;
      done = 1'b0;
      if (it.first_byte) begin
         fnd      = 1'b0;
         mal      = 1'b0;
         nm_cnt   = 8'd0;
         fld_left = 8'd0;
         if (it.packet_length == 8'd0) begin
            ph       = adn_pkg::PH_IDLE;
            pkt_left = 8'd0;
            r.packet_done = 1'b1;
            name_beats_due.push_back(r);
            return;
         end
         pkt_left = it.packet_length;
         ph       = adn_pkg::PH_LEN;
      end else if (ph == adn_pkg::PH_IDLE || pkt_left == 8'd0) begin
         ph = adn_pkg::PH_IDLE;
         return;
      end

      case (ph)
         adn_pkg::PH_LEN: begin
            if (it.data_byte == 8'd0 ||
                {1'b0, it.data_byte} + 9'd1 > {1'b0, pkt_left}) begin
               mal = 1'b1;
               ph  = adn_pkg::PH_STOP;
            end else begin
               fld_left = it.data_byte;
               ph       = adn_pkg::PH_TYPE;
            end
         end
         adn_pkg::PH_TYPE: begin
            fld_left = fld_left - 8'd1;
            if (it.data_byte == adn_pkg::AdTypeNameComplete ||
                it.data_byte == adn_pkg::AdTypeNameShort) begin
               fnd = 1'b1;
               ph  = (fld_left == 8'd0) ? adn_pkg::PH_STOP : adn_pkg::PH_NAME;
            end else begin
               ph  = (fld_left == 8'd0) ? adn_pkg::PH_LEN : adn_pkg::PH_SKIP;
            end
         end
         adn_pkg::PH_NAME: begin
            if (nm_cnt < max_len_cfg) begin
               emit   = 1'b1;
               nm_cnt = nm_cnt + 8'd1;
            end
            fld_left = fld_left - 8'd1;
            if (fld_left == 8'd0) ph = adn_pkg::PH_STOP;
         end
         adn_pkg::PH_SKIP: begin
            fld_left = fld_left - 8'd1;
            if (fld_left == 8'd0) ph = adn_pkg::PH_LEN;
         end
         default: ;
      endcase

      pkt_left = pkt_left - 8'd1;
      if (pkt_left == 8'd0) begin
         done = 1'b1;
         ph   = adn_pkg::PH_IDLE;
      end
      if (!emit && !done) return;
      r.name_valid  = emit;
      r.name_byte   = emit ? it.data_byte : 8'd0;
      r.packet_done = done;
      r.name_found  = done ? fnd : 1'b0;
      r.malformed   = done ? mal : 1'b0;
      r.name_length = done ? nm_cnt : 8'd0;
      name_beats_due.push_back(r);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         offering = 1'b0;
         ph       = adn_pkg::PH_IDLE;
         pkt_left = 8'd0;
         fld_left = 8'd0;
         nm_cnt   = 8'd0;
         fnd      = 1'b0;
         mal      = 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            step_parser(on_wire);
            offering = 1'b0;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_bytes.size() > 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
               on_wire = pending_bytes.pop_front();
               offering = 1'b1;
               req_chan.valid         <= 1'b1;
               req_chan.data_byte     <= on_wire.data_byte;
               req_chan.first_byte    <= on_wire.first_byte;
               req_chan.packet_length <= on_wire.packet_length;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      adn_pkg::result_type due;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            rsp_beats++;
            if (name_beats_due.size() == 0) begin
               $error("unexpected result beat");
               fail_count++;
            end else begin
               due = name_beats_due.pop_front();
               check_field("name_valid", 8'(due.name_valid), 8'(rsp_chan.name_valid));
               check_field("name_byte", due.name_byte, rsp_chan.name_byte);
               check_field("packet_done", 8'(due.packet_done), 8'(rsp_chan.packet_done));
               check_field("name_found", 8'(due.name_found), 8'(rsp_chan.name_found));
               check_field("malformed", 8'(due.malformed), 8'(rsp_chan.malformed));
               check_field("name_length", due.name_length, rsp_chan.name_length);
            end
         end
         // long hold-off so the block backs up onto its input
         if (rsp_chan.valid && rsp_chan.ready && (rsp_beats == 60 || rsp_beats == 300)) begin
            hold_left <= HoldCycles;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= no_idle || ($urandom_range(99) >= IdlePct);
         end
      end
   end

   task automatic push_byte(input logic [7:0] d, input logic f, input logic [7:0] pl);
      adn_pkg::item_type it;
      it.data_byte     = d;
      it.first_byte    = f;
      it.packet_length = pl;
      pending_bytes.push_back(it);
   endtask

   task automatic settle();
      while (pending_bytes.size() > 0 || offering || name_beats_due.size() > 0)
         @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [7:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      max_len_cfg <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // mode: 0 well-formed, 1 malformed, 2 abandoned part-way, 3 one long name
   task automatic push_packet(input int mode, inout int count);
      logic [7:0] body[$];
      int n_ad;
      int pay;
      int sel;
      int plen;
      int sent;
      logic [7:0] ty;
      n_ad = (mode == 3) ? 1 : $urandom_range(1, 4);
      for (int k = 0; k < n_ad; k++) begin
         if (mode == 3) pay = $urandom_range(200, 252);
         else if ($urandom_range(9) == 0) pay = $urandom_range(13, 60);
         else pay = $urandom_range(0, 12);
         if (body.size() + pay + 2 > 255) break;
         sel = $urandom_range(9);
         if (mode == 3 || sel < 3) ty = adn_pkg::AdTypeNameComplete;
         else if (sel < 5) ty = adn_pkg::AdTypeNameShort;
         else ty = 8'($urandom);
         body.push_back(8'(pay + 1));
         body.push_back(ty);
         for (int j = 0; j < pay; j++) body.push_back(8'($urandom));
      end
      plen = body.size();
      sent = plen;
      if (mode == 1) begin
         sel = $urandom_range(2);
         if (sel == 0 && plen > 1) begin
            plen = $urandom_range(1, plen - 1);
         end else if (sel == 1) begin
            body.push_back(8'h00);
            plen = body.size() + $urandom_range(0, 5);
            if (plen > 255) plen = 255;
         end else begin
            plen = $urandom_range(plen, 255);
         end
         sent = plen;
      end else if (mode == 2 && plen > 1) begin
         sent = $urandom_range(1, plen - 1);
      end
      for (int i = 0; i < sent; i++) begin
         push_byte((i < body.size()) ? body[i] : 8'($urandom), i == 0,
                   (i == 0) ? 8'(plen) : 8'($urandom));
         count++;
      end
   endtask

   initial begin
      int count;
      int sel;
      int lim;
      logic [7:0] phase_cfg[6];
      req_chan.valid         = 1'b0;
      req_chan.data_byte     = 8'd0;
      req_chan.first_byte    = 1'b0;
      req_chan.packet_length = 8'd0;
      rsp_chan.ready         = 1'b0;
      csr_wr_en              = 1'b0;
      csr_wr_data            = 8'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty packet, stray byte, plain name, zero length, overrun
      push_byte(8'hAA, 1'b1, 8'd0);
      push_byte(8'hFF, 1'b0, 8'hFF);
      push_byte(8'h03, 1'b1, 8'd4);
      push_byte(adn_pkg::AdTypeNameComplete, 1'b0, 8'h00);
      push_byte(8'h41, 1'b0, 8'h5A);
      push_byte(8'h42, 1'b0, 8'hA5);
      push_byte(8'h00, 1'b1, 8'd1);
      push_byte(8'h05, 1'b1, 8'd2);
      push_byte(adn_pkg::AdTypeNameComplete, 1'b0, 8'd0);
      // abandoned packet, then a name with no characters
      push_byte(8'h04, 1'b1, 8'd5);
      push_byte(adn_pkg::AdTypeNameComplete, 1'b0, 8'd0);
      push_byte(8'h78, 1'b0, 8'd0);
      push_byte(8'h01, 1'b1, 8'd2);
      push_byte(adn_pkg::AdTypeNameComplete, 1'b0, 8'd0);
      // second name after the first is not parsed
      push_byte(8'h02, 1'b1, 8'd6);
      push_byte(adn_pkg::AdTypeNameShort, 1'b0, 8'd0);
      push_byte(8'h71, 1'b0, 8'd0);
      push_byte(8'h02, 1'b0, 8'd0);
      push_byte(adn_pkg::AdTypeNameComplete, 1'b0, 8'd0);
      push_byte(8'h72, 1'b0, 8'd0);

      // truncation to the limit
      write_max_len(8'd2);
      push_byte(8'h05, 1'b1, 8'd6);
      push_byte(adn_pkg::AdTypeNameComplete, 1'b0, 8'd0);
      push_byte(8'h61, 1'b0, 8'd0);
      push_byte(8'h62, 1'b0, 8'd0);
      push_byte(8'h63, 1'b0, 8'd0);
      push_byte(8'h64, 1'b0, 8'd0);

      phase_cfg[0] = 8'd0;
      phase_cfg[1] = 8'd255;
      phase_cfg[2] = 8'($urandom_range(3, 40));
      phase_cfg[3] = 8'd1;
      phase_cfg[4] = 8'($urandom);
      phase_cfg[5] = adn_pkg::MaxNameLenReset;
      for (int p = 0; p < 6; p++) begin
         write_max_len(phase_cfg[p]);
         no_idle <= (p == 2);
         count = 0;
         if (phase_cfg[p] == 8'd255) begin
            push_packet(3, count);
            push_packet(3, count);
         end
         while (count < PhaseBytes) begin
            sel = $urandom_range(99);
            if (sel < 70) push_packet(0, count);
            else if (sel < 80) push_packet(1, count);
            else if (sel < 88) push_packet(2, count);
            else if (sel < 93) begin
               push_byte(8'($urandom), 1'b1, 8'd0);
               count++;
            end else begin
               repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0, 8'($urandom));
            end
         end
      end
      no_idle <= 1'b0;

      while (pending_bytes.size() > 0 || offering) @(posedge clock);
      lim = 0;
      while (name_beats_due.size() > 0 && lim < 5000) begin
         @(posedge clock);
         lim++;
      end
      if (name_beats_due.size() > 0) begin
         $error("%0d result beats never arrived", name_beats_due.size());
         fail_count++;
      end
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
